@@ hdl/rbi_pkg.sv @@
// Package for the ray / axis-aligned box intersection core.
// Holds item structs, face tables, register indexes and shared constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rbi_pkg;

  localparam int NUM_FACES = 6;
  localparam int NUM_AXES  = 3;
  // One quotient bit per step: the overflow bit 31, then bits 30 down to 0.
  localparam int DIV_STEPS = 32;
  localparam int REM_W     = 64;

  localparam logic [30:0] T_MAX = 31'h7FFF_FFFF;

  // Register indexes of the configuration port
  localparam logic [2:0] REG_BOX_X_MIN    = 3'd0;
  localparam logic [2:0] REG_BOX_X_MAX    = 3'd1;
  localparam logic [2:0] REG_BOX_Y_MIN    = 3'd2;
  localparam logic [2:0] REG_BOX_Y_MAX    = 3'd3;
  localparam logic [2:0] REG_BOX_Z_MIN    = 3'd4;
  localparam logic [2:0] REG_BOX_Z_MAX    = 3'd5;
  localparam logic [2:0] REG_MIN_DISTANCE = 3'd6;

  // Scan order: z-min, x-max, y-min, x-min, z-max, y-max
  localparam logic [1:0] FACE_AXIS   [NUM_FACES] = '{2'd2, 2'd0, 2'd1, 2'd0, 2'd2, 2'd1};
  localparam logic       FACE_IS_MAX [NUM_FACES] = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1};

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
  } ray_in_t;

  typedef struct packed {
    logic        hit;
    logic [1:0]  hit_count;
    logic [30:0] t_near;
    logic [30:0] t_far;
    logic [2:0]  near_face;
  } ray_out_t;

  // The two axes tested for a hit point on a face of axis a
  function automatic logic [1:0] other_axis(input logic [1:0] a, input logic j);
    logic [1:0] r;
    r = 2'd0;
    case (a)
      2'd0:    r = j ? 2'd2 : 2'd1;
      2'd1:    r = j ? 2'd0 : 2'd2;
      default: r = j ? 2'd1 : 2'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hdl/ray_box_intersection_core.sv @@
// Ray / axis-aligned box intersection core, fully pipelined.
// Stages, in order: entry register, 32 divider steps, multiply stage,
// bound-test stage, select/sort register. Throughput: one item per cycle
// unless the output stalls; the six face dividers, one quotient bit
// per stage each, set the depth. A stalled output freezes the whole pipe.
// Reset: asynchronous, active low; clears valid bits and loads the box
// bounds to -1.0/+1.0 and the epsilon to 66. No clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module ray_box_intersection_core #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire rbi_pkg::ray_in_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output rbi_pkg::ray_out_t      out_data_o,
  input  wire logic              cfg_we_i,
  input  wire logic [2:0]        cfg_idx_i,
  input  wire logic [31:0]       cfg_data_i
);
  import rbi_pkg::*;

  localparam logic [REM_W-1:0] ROUND_M1 = REM_W'((64'd1 << COORD_FRAC_BITS) - 64'd1);

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  logic signed [31:0] box_lo_q [NUM_AXES];
  logic signed [31:0] box_hi_q [NUM_AXES];
  logic [15:0]        min_dist_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        box_lo_q[a] <= -32'sd65536;
        box_hi_q[a] <= 32'sd65536;
      end
      min_dist_q <= 16'd66;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BOX_X_MIN:    box_lo_q[0] <= cfg_data_i;
        REG_BOX_X_MAX:    box_hi_q[0] <= cfg_data_i;
        REG_BOX_Y_MIN:    box_lo_q[1] <= cfg_data_i;
        REG_BOX_Y_MAX:    box_hi_q[1] <= cfg_data_i;
        REG_BOX_Z_MIN:    box_lo_q[2] <= cfg_data_i;
        REG_BOX_Z_MAX:    box_hi_q[2] <= cfg_data_i;
        REG_MIN_DISTANCE: min_dist_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Whole pipe advances together; hold everything while the result waits.
  logic en;
  logic out_valid_q;
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // ---------------------------------------------------------------
  // Entry and divider stages: stage 0 is the entry register, stage s
  // resolves quotient bit DIV_STEPS-s. Quotient bit 31 flags saturation.
  // ---------------------------------------------------------------
  logic             dv_q   [DIV_STEPS+1];
  ray_in_t          ray_q  [DIV_STEPS+1];
  logic [REM_W-1:0] rem_q  [DIV_STEPS+1][NUM_FACES];
  logic [REM_W-1:0] rem_d  [DIV_STEPS+1][NUM_FACES];
  logic [31:0]      den_q  [DIV_STEPS+1][NUM_FACES];
  logic [31:0]      den_d  [DIV_STEPS+1][NUM_FACES];
  logic [31:0]      quo_q  [DIV_STEPS+1][NUM_FACES];
  logic [31:0]      quo_d  [DIV_STEPS+1][NUM_FACES];
  logic             skip_q [DIV_STEPS+1][NUM_FACES];
  logic             skip_d [DIV_STEPS+1][NUM_FACES];

  logic signed [31:0] in_org [NUM_AXES];
  logic signed [31:0] in_dir [NUM_AXES];
  assign in_org[0] = in_data_i.origin_x;
  assign in_org[1] = in_data_i.origin_y;
  assign in_org[2] = in_data_i.origin_z;
  assign in_dir[0] = in_data_i.dir_x;
  assign in_dir[1] = in_data_i.dir_y;
  assign in_dir[2] = in_data_i.dir_z;

  always_comb begin
    logic signed [31:0] plane;
    logic signed [31:0] d;
    logic signed [32:0] diff;
    logic [31:0]        abs_diff;
    logic [REM_W-1:0]   dsh;
    logic               ge;
    for (int f = 0; f < NUM_FACES; f++) begin
      // Plane distance numerator and divisor magnitudes; skip parallel faces,
      // backward faces and faces the origin lies on.
      plane    = FACE_IS_MAX[f] ? box_hi_q[FACE_AXIS[f]] : box_lo_q[FACE_AXIS[f]];
      d        = in_dir[FACE_AXIS[f]];
      diff     = {plane[31], plane} - {in_org[FACE_AXIS[f]][31], in_org[FACE_AXIS[f]]};
      abs_diff = diff[32] ? 32'(-diff) : diff[31:0];
      skip_d[0][f] = (d == 32'sd0) || (diff == 33'sd0) || (diff[32] != d[31]);
      rem_d[0][f]  = {32'b0, abs_diff} << COORD_FRAC_BITS;
      den_d[0][f]  = d[31] ? 32'(-d) : 32'(d);
      quo_d[0][f]  = 32'b0;
    end
    for (int s = 1; s <= DIV_STEPS; s++) begin
      for (int f = 0; f < NUM_FACES; f++) begin
        dsh = {32'b0, den_q[s-1][f]} << (DIV_STEPS - s);
        ge  = rem_q[s-1][f] >= dsh;
        rem_d[s][f]  = rem_q[s-1][f];
        quo_d[s][f]  = quo_q[s-1][f];
        den_d[s][f]  = den_q[s-1][f];
        skip_d[s][f] = skip_q[s-1][f];
        // Once saturated, leave the remainder alone.
        if (!quo_q[s-1][f][31] && ge) begin
          rem_d[s][f]              = rem_q[s-1][f] - dsh;
          quo_d[s][f][DIV_STEPS-s] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= DIV_STEPS; s++) begin
        dv_q[s] <= 1'b0;
      end
    end else if (en) begin
      dv_q[0] <= in_valid_i;
      for (int s = 1; s <= DIV_STEPS; s++) begin
        dv_q[s] <= dv_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ray_q[0] <= in_data_i;
      for (int s = 1; s <= DIV_STEPS; s++) begin
        ray_q[s] <= ray_q[s-1];
      end
      for (int s = 0; s <= DIV_STEPS; s++) begin
        for (int f = 0; f < NUM_FACES; f++) begin
          rem_q[s][f]  <= rem_d[s][f];
          den_q[s][f]  <= den_d[s][f];
          quo_q[s][f]  <= quo_d[s][f];
          skip_q[s][f] <= skip_d[s][f];
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // Multiply stage: saturate t, test epsilon, form t * |dir| for the two
  // cross axes of every face.
  // ---------------------------------------------------------------
  logic signed [31:0] dv_org [NUM_AXES];
  logic signed [31:0] dv_dir [NUM_AXES];
  assign dv_org[0] = ray_q[DIV_STEPS].origin_x;
  assign dv_org[1] = ray_q[DIV_STEPS].origin_y;
  assign dv_org[2] = ray_q[DIV_STEPS].origin_z;
  assign dv_dir[0] = ray_q[DIV_STEPS].dir_x;
  assign dv_dir[1] = ray_q[DIV_STEPS].dir_y;
  assign dv_dir[2] = ray_q[DIV_STEPS].dir_z;

  logic               mv_q;
  logic signed [31:0] morg_q  [NUM_AXES];
  logic [30:0]        mt_q    [NUM_FACES];
  logic [30:0]        mt_d    [NUM_FACES];
  logic               meps_q  [NUM_FACES];
  logic               meps_d  [NUM_FACES];
  logic [62:0]        mprod_q [NUM_FACES][2];
  logic [62:0]        mprod_d [NUM_FACES][2];
  logic               mneg_q  [NUM_FACES][2];
  logic               mneg_d  [NUM_FACES][2];

  always_comb begin
    logic [1:0]         b;
    logic signed [31:0] db;
    logic [31:0]        mag;
    for (int f = 0; f < NUM_FACES; f++) begin
      mt_d[f]   = quo_q[DIV_STEPS][f][31] ? T_MAX : quo_q[DIV_STEPS][f][30:0];
      meps_d[f] = !skip_q[DIV_STEPS][f] && (mt_d[f] > {15'b0, min_dist_q});
      for (int j = 0; j < 2; j++) begin
        b   = other_axis(FACE_AXIS[f], j[0]);
        db  = dv_dir[b];
        mag = db[31] ? 32'(-db) : 32'(db);
        mprod_d[f][j] = {32'b0, mt_d[f]} * {31'b0, mag};
        mneg_d[f][j]  = db[31];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q <= 1'b0;
    end else if (en) begin
      mv_q <= dv_q[DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        morg_q[a] <= dv_org[a];
      end
      for (int f = 0; f < NUM_FACES; f++) begin
        mt_q[f]   <= mt_d[f];
        meps_q[f] <= meps_d[f];
        for (int j = 0; j < 2; j++) begin
          mprod_q[f][j] <= mprod_d[f][j];
          mneg_q[f][j]  <= mneg_d[f][j];
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // Bound-test stage: hit point with floor rounding, inclusive bounds.
  // ---------------------------------------------------------------
  logic        pv_q;
  logic        phit_q [NUM_FACES];
  logic        phit_d [NUM_FACES];
  logic [30:0] pt_q   [NUM_FACES];

  always_comb begin
    logic [1:0]              b;
    logic [REM_W-1:0]        up;
    logic signed [REM_W-1:0] stp;
    logic signed [REM_W-1:0] p;
    logic signed [REM_W-1:0] lo;
    logic signed [REM_W-1:0] hi;
    logic                    in_box;
    for (int f = 0; f < NUM_FACES; f++) begin
      in_box = 1'b1;
      for (int j = 0; j < 2; j++) begin
        b  = other_axis(FACE_AXIS[f], j[0]);
        up = mneg_q[f][j] ? (({1'b0, mprod_q[f][j]} + ROUND_M1) >> COORD_FRAC_BITS)
                          : ({1'b0, mprod_q[f][j]} >> COORD_FRAC_BITS);
        stp = mneg_q[f][j] ? -$signed(up) : $signed(up);
        p   = REM_W'(morg_q[b]) + stp;
        lo  = REM_W'(box_lo_q[b]);
        hi  = REM_W'(box_hi_q[b]);
        if (p < lo || p > hi) begin
          in_box = 1'b0;
        end
      end
      phit_d[f] = meps_q[f] && in_box;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else if (en) begin
      pv_q <= mv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int f = 0; f < NUM_FACES; f++) begin
        phit_q[f] <= phit_d[f];
        pt_q[f]   <= mt_q[f];
      end
    end
  end

  // ---------------------------------------------------------------
  // Select the first two hits in scan order, sort, register the result.
  // ---------------------------------------------------------------
  ray_out_t out_d;
  ray_out_t out_q;

  always_comb begin
    logic [1:0]  cnt;
    logic [30:0] t0;
    logic [30:0] t1;
    logic [2:0]  f0;
    logic [2:0]  f1;
    cnt = 2'd0;
    t0  = '0;
    t1  = '0;
    f0  = '0;
    f1  = '0;
    for (int f = 0; f < NUM_FACES; f++) begin
      if (phit_q[f] && cnt != 2'd2) begin
        if (cnt == 2'd0) begin
          t0 = pt_q[f];
          f0 = 3'(f);
        end else begin
          t1 = pt_q[f];
          f1 = 3'(f);
        end
        cnt = cnt + 2'd1;
      end
    end
    out_d           = '0;
    out_d.hit_count = cnt;
    out_d.hit       = cnt != 2'd0;
    if (cnt == 2'd1) begin
      out_d.t_near    = t0;
      out_d.t_far     = {15'b0, min_dist_q};
      out_d.near_face = f0;
    end else if (cnt == 2'd2) begin
      // Equal distances pick the second hit as the nearer one.
      if (t0 < t1) begin
        out_d.t_near    = t0;
        out_d.t_far     = t1;
        out_d.near_face = f0;
      end else begin
        out_d.t_near    = t1;
        out_d.t_far     = t0;
        out_d.near_face = f1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= pv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  a_hit_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.hit == (out_q.hit_count != 2'd0)))
    else $error("hit flag disagrees with hit count");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.hit_count != 2'd3 && out_q.near_face < 3'd6))
    else $error("hit count or face out of range");

  a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.hit_count == 2'd2) |-> (out_q.t_near <= out_q.t_far))
    else $error("hit distances not sorted");

  a_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> dv_q[0])
    else $error("accepted item not captured");

endmodule

`default_nettype wire

@@ verif/ray_box_intersection_core_test.sv @@
// Self-checking testbench for ray_box_intersection_core: rays against a register-held box.
// A local predictor computes each face hit, checks every result in order; uses rbi_pkg.
`timescale 1ns / 1ps

module ray_box_intersection_core_test;
  import rbi_pkg::*;

  localparam int FRAC = 16;
  localparam int LATENCY = 36;
  localparam int IDLE_LIMIT = 20000;
  // Index past the register list; writes to it are ignored
  localparam logic [2:0] REG_NONE = 3'd7;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  ray_in_t in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  ray_out_t out_data_o;
  logic cfg_we_i;
  logic [2:0] cfg_idx_i;
  logic [31:0] cfg_data_i;

  ray_box_intersection_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  always begin
    clk_i = 1'b0; #6;
    clk_i = 1'b1; #6;
  end

  // Predictor copy of the box registers, indexed by axis (0 x, 1 y, 2 z)
  longint box_lo [3];
  longint box_hi [3];
  longint epsilon;

  ray_in_t rays_pending[$];
  ray_out_t hits_expected[$];
  int errors = 0;
  int rays_sent = 0;
  int results_seen = 0;
  int hits_two = 0;
  int hits_one = 0;
  bit sender_hold;
  bit stim_done;

  function automatic longint magnitude(longint v);
    return v < 0 ? -v : v;
  endfunction

  // floor(t * d / 2^FRAC) for the hit point along another axis
  function automatic longint travel(longint t, longint d);
    longint m;
    m = t * magnitude(d);
    if (d < 0) return -((m + (64'sd1 << FRAC) - 1) >>> FRAC);
    return m >>> FRAC;
  endfunction

  function automatic ray_out_t trace_box(ray_in_t r);
    longint org [3];
    longint dir [3];
    longint tv [2];
    logic [2:0] fc [2];
    longint plane, diff, q, p;
    int cnt, a, b;
    bit in_box;
    ray_out_t res;
    org[0] = r.origin_x; org[1] = r.origin_y; org[2] = r.origin_z;
    dir[0] = r.dir_x; dir[1] = r.dir_y; dir[2] = r.dir_z;
    cnt = 0;
    tv[0] = 0; tv[1] = 0; fc[0] = 0; fc[1] = 0;
    for (int f = 0; f < NUM_FACES && cnt < 2; f++) begin
      a = FACE_AXIS[f];
      plane = FACE_IS_MAX[f] ? box_hi[a] : box_lo[a];
      if (dir[a] == 0) continue;
      diff = plane - org[a];
      // skip faces behind the origin or on it
      if (diff == 0 || ((diff < 0) != (dir[a] < 0))) continue;
      q = (magnitude(diff) << FRAC) / magnitude(dir[a]);
      if (q > longint'(T_MAX)) q = T_MAX;
      if (q <= epsilon) continue;
      in_box = 1'b1;
      for (int j = 1; j < 3; j++) begin
        b = (a + j) % 3;
        p = org[b] + travel(q, dir[b]);
        if (p < box_lo[b] || p > box_hi[b]) in_box = 1'b0;
      end
      if (!in_box) continue;
      tv[cnt] = q;
      fc[cnt] = 3'(f);
      cnt++;
    end
    res = '0;
    if (cnt == 1) begin
      res.hit = 1'b1; res.hit_count = 2'd1;
      res.t_near = 31'(tv[0]); res.t_far = 31'(epsilon); res.near_face = fc[0];
    end else if (cnt == 2) begin
      res.hit = 1'b1; res.hit_count = 2'd2;
      // on a tie the later hit counts as nearer
      if (tv[0] < tv[1]) begin
        res.t_near = 31'(tv[0]); res.t_far = 31'(tv[1]); res.near_face = fc[0];
      end else begin
        res.t_near = 31'(tv[1]); res.t_far = 31'(tv[0]); res.near_face = fc[1];
      end
    end
    return res;
  endfunction

  // Write one register on the port and in the predictor; only while idle
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_BOX_X_MIN: box_lo[0] = longint'($signed(val));
      REG_BOX_X_MAX: box_hi[0] = longint'($signed(val));
      REG_BOX_Y_MIN: box_lo[1] = longint'($signed(val));
      REG_BOX_Y_MAX: box_hi[1] = longint'($signed(val));
      REG_BOX_Z_MIN: box_lo[2] = longint'($signed(val));
      REG_BOX_Z_MAX: box_hi[2] = longint'($signed(val));
      REG_MIN_DISTANCE: epsilon = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_box(int lo, int hi, logic [15:0] eps);
    write_reg(REG_BOX_X_MIN, lo); write_reg(REG_BOX_X_MAX, hi);
    write_reg(REG_BOX_Y_MIN, lo); write_reg(REG_BOX_Y_MAX, hi);
    write_reg(REG_BOX_Z_MIN, lo); write_reg(REG_BOX_Z_MAX, hi);
    write_reg(REG_MIN_DISTANCE, {16'd0, eps});
  endtask

  // Wait until every queued ray is sent and answered, then drain the pipe
  task automatic settle();
    do begin
      while (rays_pending.size() != 0 || hits_expected.size() != 0 || in_valid_i)
        @(posedge clk_i);
      repeat (LATENCY + 4) @(posedge clk_i);
    end while (rays_pending.size() != 0 || hits_expected.size() != 0 || in_valid_i);
  endtask

  function automatic ray_in_t make_ray(int ox, int oy, int oz, int dx, int dy, int dz);
    ray_in_t r;
    r.origin_x = ox; r.origin_y = oy; r.origin_z = oz;
    r.dir_x = dx; r.dir_y = dy; r.dir_z = dz;
    return r;
  endfunction

  function automatic int pick_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $signed($urandom_range(0, 6 * 65536)) - 3 * 65536;
      2: return $signed($urandom_range(0, 1024)) - 512;
      3: return 0;
      4: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $signed($urandom_range(0, 2 * 65536)) - 65536;
    endcase
  endfunction

  function automatic int pick_dir();
    case ($urandom_range(0, 6))
      0: return 0;
      1: return $urandom;
      2: return $signed($urandom_range(0, 16)) - 8;
      3: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $signed($urandom_range(0, 4 * 65536)) - 2 * 65536;
    endcase
  endfunction

  // Aim a ray from a random origin toward a random point within +/-0.5 of the centre
  function automatic ray_in_t aimed_ray();
    int ox, oy, oz;
    ox = $signed($urandom_range(0, 8 * 65536)) - 4 * 65536;
    oy = $signed($urandom_range(0, 8 * 65536)) - 4 * 65536;
    oz = $signed($urandom_range(0, 8 * 65536)) - 4 * 65536;
    return make_ray(ox, oy, oz,
                    ($signed($urandom_range(0, 65536)) - 32768 - ox) / 2,
                    ($signed($urandom_range(0, 65536)) - 32768 - oy) / 2,
                    ($signed($urandom_range(0, 65536)) - 32768 - oz) / 2);
  endfunction

  task automatic random_rays(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 65) rays_pending.push_back(aimed_ray());
      else rays_pending.push_back(make_ray(pick_coord(), pick_coord(), pick_coord(),
                                           pick_dir(), pick_dir(), pick_dir()));
    end
  endtask

  // Driver: bursts of items separated by random gaps
  int burst_left;
  int gap_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        hits_expected.push_back(trace_box(in_data_i));
        rays_sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (rays_pending.size() != 0 && !sender_hold) begin
          in_valid_i <= 1'b1;
          in_data_i <= rays_pending.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern: mostly ready, with stall stretches of its own
  int stall_phase;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_phase <= 0;
    end else begin
      stall_phase <= stall_phase + 1;
      if (stall_phase[9:8] == 2'd3) out_ready_i <= 1'b1;
      else out_ready_i <= ($urandom_range(0, 3) != 0) || stall_phase[4];
    end
  end

  // Monitor: compare each result with the oldest expectation
  always @(posedge clk_i) begin
    ray_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (hits_expected.size() == 0) begin
        $error("unexpected result %p", out_data_o);
        errors++;
      end else begin
        want = hits_expected.pop_front();
        if (want.hit_count == 2) hits_two++;
        if (want.hit_count == 1) hits_one++;
        if (out_data_o.hit !== want.hit) begin
          $error("hit: expected %0d actual %0d", want.hit, out_data_o.hit); errors++;
        end
        if (out_data_o.hit_count !== want.hit_count) begin
          $error("hit_count: expected %0d actual %0d", want.hit_count,
                 out_data_o.hit_count);
          errors++;
        end
        if (out_data_o.t_near !== want.t_near) begin
          $error("t_near: expected %h actual %h", want.t_near, out_data_o.t_near);
          errors++;
        end
        if (out_data_o.t_far !== want.t_far) begin
          $error("t_far: expected %h actual %h", want.t_far, out_data_o.t_far);
          errors++;
        end
        if (out_data_o.near_face !== want.near_face) begin
          $error("near_face: expected %0d actual %0d", want.near_face,
                 out_data_o.near_face);
          errors++;
        end
      end
    end
  end

  // Watchdog: cycles without any accepted item on either side
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || stim_done)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int lim;
    sender_hold = 1'b0; stim_done = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_data_i = '0;
    for (int a = 0; a < 3; a++) begin
      box_lo[a] = -65536; box_hi[a] = 65536;
    end
    epsilon = 66;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset box, axis rays, parallel faces, origin on a face,
    // field extremes, saturated distance, corner ties
    rays_pending.push_back(make_ray(0, 0, -3 * 65536, 0, 0, 65536));
    rays_pending.push_back(make_ray(3 * 65536, 0, 0, -65536, 0, 0));
    rays_pending.push_back(make_ray(0, 3 * 65536, 0, 0, -65536, 0));
    rays_pending.push_back(make_ray(0, 0, 0, 65536, 0, 0));
    rays_pending.push_back(make_ray(0, 0, 0, 0, 0, 0));
    rays_pending.push_back(make_ray(-65536, 0, 0, 65536, 0, 0));
    rays_pending.push_back(make_ray(-2 * 65536, -2 * 65536, -2 * 65536, 65536, 65536, 65536));
    rays_pending.push_back(make_ray(0, 0, 0, 1, 0, 0));
    rays_pending.push_back(make_ray(0, 0, 65535, 0, 0, 1));
    rays_pending.push_back(make_ray(32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 0));
    rays_pending.push_back(make_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                    32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    rays_pending.push_back(make_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    rays_pending.push_back(make_ray(0, 0, -2 * 65536, 32'hFFFF_FFFF, 1, 65536));
    rays_pending.push_back(make_ray(0, 0, 65536 + 1, 0, 0, -1));
    rays_pending.push_back(make_ray(-1, -1, -1, 32'h8000_0000, 32'h7FFF_FFFF, 1));
    random_rays(300);
    // Hold the sender until the pipe is fully drained once
    while (rays_pending.size() > 150) @(posedge clk_i);
    sender_hold = 1'b1;
    while (hits_expected.size() != 0 || in_valid_i) @(posedge clk_i);
    sender_hold = 1'b0;
    settle();

    // Wide box, zero epsilon
    set_box(32'h8000_0000, 32'h7FFF_FFFF, 16'd0);
    random_rays(250);
    settle();
    // Inverted bounds on one axis, largest epsilon
    set_box(-2 * 65536, 2 * 65536, 16'hFFFF);
    write_reg(REG_BOX_Y_MIN, 65536);
    write_reg(REG_BOX_Y_MAX, -65536);
    random_rays(150);
    settle();
    // Several random boxes with random epsilon
    for (int k = 0; k < 5; k++) begin
      lim = $urandom_range(1, 4 * 65536);
      set_box(-lim, lim, $urandom_range(0, 1) ? 16'($urandom) : 16'd0);
      write_reg(REG_BOX_Z_MIN, -lim / 3);
      random_rays(150);
      settle();
    end
    write_reg(REG_NONE, $urandom);
    random_rays(4);
    settle();

    stim_done = 1'b1;
    $display("Sent %0d rays over 8 box settings; %0d results, %0d single and %0d double hits.",
             rays_sent, results_seen, hits_one, hits_two);
    if (errors == 0 && hits_expected.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
